@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is low
`define SBMQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// boolean condition that must never be seen
`define SBMQ_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  `SBMQ_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

@@ hw/rtl/sbmq_pkg.sv @@
// shared constants and datapath command and status types for the sorted byte queue
package sbmq_pkg;

  localparam int unsigned StoreDepthDefault = 64;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ReqW    = 6;
  localparam int unsigned StatusW = 3;

  localparam logic [FuncW-1:0] FuncWrite = 2'd0;
  localparam logic [FuncW-1:0] FuncRead  = 2'd1;
  localparam logic [FuncW-1:0] FuncClear = 2'd2;

  localparam logic [StatusW-1:0] StatAccepted = 3'd0;
  localparam logic [StatusW-1:0] StatFull     = 3'd1;
  localparam logic [StatusW-1:0] StatData     = 3'd2;
  localparam logic [StatusW-1:0] StatEmpty    = 3'd3;
  localparam logic [StatusW-1:0] StatCleared  = 3'd4;

  typedef struct packed {
    logic write;
    logic shift;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [ByteW-1:0] head;
  } dp_stat_t;

endpackage

@@ hw/rtl/sbmq_dp.sv @@
// datapath: sorted byte store with parallel insert, head pop shift and fill count
module sbmq_dp #(
  parameter int unsigned StoreDepth = sbmq_pkg::StoreDepthDefault,
  localparam int unsigned Depth = StoreDepth - 1,
  localparam int unsigned FillW = $clog2(StoreDepth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [sbmq_pkg::ByteW-1:0] data_byte_i,
  input  sbmq_pkg::dp_cmd_t          cmd_i,
  output sbmq_pkg::dp_stat_t         stat_o,
  output logic [FillW-1:0]           fill_o
);

  logic [sbmq_pkg::ByteW-1:0] store_q [Depth];
  logic [sbmq_pkg::ByteW-1:0] store_d [Depth];
  logic [sbmq_pkg::ByteW-1:0] below_val [Depth];
  logic [sbmq_pkg::ByteW-1:0] above_val [Depth];
  logic [Depth-1:0]           le;
  logic [Depth-1:0]           le_prev;
  logic [FillW-1:0]           fill_q;
  logic [FillW-1:0]           fill_d;

  // held entry not above the new byte, signed compare
  for (genvar i = 0; i < Depth; i++) begin : g_cmp
    assign le[i] = (fill_q > FillW'(i)) &&
                   ($signed(store_q[i]) <= $signed(data_byte_i));
    if (i == 0) begin : g_first
      assign le_prev[i]   = 1'b1;
      assign below_val[i] = data_byte_i;
    end else begin : g_rest
      assign le_prev[i]   = le[i-1];
      assign below_val[i] = store_q[i-1];
    end
    if (i == Depth - 1) begin : g_end
      assign above_val[i] = store_q[i];
    end else begin : g_mid
      assign above_val[i] = store_q[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      store_d[i] = store_q[i];
      if (cmd_i.write) begin
        if (!le[i]) begin
          store_d[i] = le_prev[i] ? data_byte_i : below_val[i];
        end
      end else if (cmd_i.shift) begin
        store_d[i] = above_val[i];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.write) begin
      fill_d = fill_q + FillW'(1);
    end else if (cmd_i.shift) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == FillW'(Depth));
  assign stat_o.head  = store_q[0];
  assign fill_o       = fill_q;

endmodule

@@ hw/rtl/sbmq_ctrl.sv @@
// controller: request decode, drain sequencer and registered result outputs
module sbmq_ctrl #(
  parameter int unsigned StoreDepth = sbmq_pkg::StoreDepthDefault,
  localparam int unsigned FillW = $clog2(StoreDepth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sbmq_pkg::FuncW-1:0]   func_i,
  input  logic [sbmq_pkg::ReqW-1:0]    read_count_i,
  input  sbmq_pkg::dp_stat_t            stat_i,
  input  logic [FillW-1:0]              fill_i,
  output sbmq_pkg::dp_cmd_t             cmd_o,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output logic [sbmq_pkg::StatusW-1:0]  status_o,
  output logic [sbmq_pkg::ByteW-1:0]    out_byte_o,
  output logic                          last_o
);

  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  state_e                       state_q;
  logic [sbmq_pkg::ReqW-1:0]    remain_q;
  logic                         result_valid_q;
  logic [sbmq_pkg::StatusW-1:0] status_q;
  logic [sbmq_pkg::ByteW-1:0]   out_byte_q;
  logic                         last_q;

  logic                         accept;
  logic [sbmq_pkg::ReqW-1:0]    fill_ext;
  logic [sbmq_pkg::ReqW-1:0]    take_n;

  assign accept   = start_i && (state_q == StIdle);
  assign fill_ext = sbmq_pkg::ReqW'(fill_i);
  assign take_n   = (read_count_i < fill_ext) ? read_count_i : fill_ext;

  always_comb begin
    cmd_o.write = accept && (func_i == sbmq_pkg::FuncWrite) && !stat_i.full;
    cmd_o.clear = accept && (func_i == sbmq_pkg::FuncClear);
    cmd_o.shift = (state_q == StDrain);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      remain_q       <= '0;
      result_valid_q <= 1'b0;
      status_q       <= sbmq_pkg::StatAccepted;
      out_byte_q     <= '0;
      last_q         <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            unique case (func_i)
              sbmq_pkg::FuncWrite: begin
                result_valid_q <= 1'b1;
                status_q       <= stat_i.full ? sbmq_pkg::StatFull : sbmq_pkg::StatAccepted;
                out_byte_q     <= '0;
                last_q         <= 1'b1;
              end
              sbmq_pkg::FuncRead: begin
                if (stat_i.empty) begin
                  result_valid_q <= 1'b1;
                  status_q       <= sbmq_pkg::StatEmpty;
                  out_byte_q     <= '0;
                  last_q         <= 1'b1;
                end else if (take_n != '0) begin
                  state_q  <= StDrain;
                  remain_q <= take_n;
                end
              end
              sbmq_pkg::FuncClear: begin
                result_valid_q <= 1'b1;
                status_q       <= sbmq_pkg::StatCleared;
                out_byte_q     <= '0;
                last_q         <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        StDrain: begin
          result_valid_q <= 1'b1;
          status_q       <= sbmq_pkg::StatData;
          out_byte_q     <= stat_i.head;
          last_q         <= (remain_q == sbmq_pkg::ReqW'(1));
          remain_q       <= remain_q - sbmq_pkg::ReqW'(1);
          if (remain_q == sbmq_pkg::ReqW'(1)) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o         = (state_q == StDrain);
  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign out_byte_o     = out_byte_q;
  assign last_o         = last_q;

endmodule

@@ hw/rtl/sorted_byte_min_queue_top.sv @@
// top level of the sorted byte minimum queue
//
//   channel   handshake                 payload
//   request   start / busy              func_i, data_byte_i, read_count_i
//   result    result_valid_o (strobe)   status_o, out_byte_o, last_o
//
// write, clear, empty read: one result in the cycle after the request, next request
//   may follow at once (one request per cycle)
// read of n bytes: min(n, fill count) results, smallest byte first, busy high until the last one;
//   one byte per cycle, set by the single head-pop shift of the store
// reset clears the fill count and the controller; store contents need no clearing
// results cannot be stalled: each shows for one cycle only
module sorted_byte_min_queue_top #(
  parameter int unsigned StoreDepth = sbmq_pkg::StoreDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [sbmq_pkg::FuncW-1:0]   func_i,
  input  logic [sbmq_pkg::ByteW-1:0]   data_byte_i,
  input  logic [sbmq_pkg::ReqW-1:0]    read_count_i,
  output logic                         result_valid_o,
  output logic [sbmq_pkg::StatusW-1:0] status_o,
  output logic [sbmq_pkg::ByteW-1:0]   out_byte_o,
  output logic                         last_o
);

  localparam int unsigned FillW = $clog2(StoreDepth);

  sbmq_pkg::dp_cmd_t  cmd;
  sbmq_pkg::dp_stat_t stat;
  logic [FillW-1:0]   fill;

  sbmq_ctrl #(
    .StoreDepth(StoreDepth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .func_i        (func_i),
    .read_count_i  (read_count_i),
    .stat_i        (stat),
    .fill_i        (fill),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

  sbmq_dp #(
    .StoreDepth(StoreDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_byte_i(data_byte_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .fill_o     (fill)
  );

endmodule

@@ hw/rtl/sbmq_checker.sv @@
// port-level assertions for the sorted byte queue and their bind to the top level
`include "assert_macros.svh"

module sbmq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [sbmq_pkg::FuncW-1:0]   func_i,
  input logic [sbmq_pkg::ReqW-1:0]    read_count_i,
  input logic                         result_valid_o,
  input logic [sbmq_pkg::StatusW-1:0] status_o,
  input logic [sbmq_pkg::ByteW-1:0]   out_byte_o,
  input logic                         last_o
);

  // status results carry no byte and always end their request
  `SBMQ_ASSERT_NEVER(a_status_shape, clk_i, rst_ni, result_valid_o && (status_o != sbmq_pkg::StatData) && ((out_byte_o != '0) || !last_o), "status result with byte or without last")

  // write and clear requests answer in the next cycle
  `SBMQ_ASSERT(a_single_answer, clk_i, rst_ni, start && !busy && ((func_i == sbmq_pkg::FuncWrite) || (func_i == sbmq_pkg::FuncClear)) |=> result_valid_o && last_o, "write or clear without a result")

  // busy only rises after a read request with a nonzero count
  `SBMQ_ASSERT(a_busy_cause, clk_i, rst_ni, $rose(busy) |-> $past(start && (func_i == sbmq_pkg::FuncRead) && (read_count_i != '0)), "busy without a read request")

  // a drain keeps going until its flagged byte
  `SBMQ_ASSERT(a_drain_run, clk_i, rst_ni, result_valid_o && !last_o |=> result_valid_o && (status_o == sbmq_pkg::StatData), "drain broken before last byte")

endmodule

bind sorted_byte_min_queue_top sbmq_checker u_sbmq_checker (.*);

@@ test/tb.sv @@
// testbench for the sorted byte min queue: directed table, then random requests checked by a predictor
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Capacity = sbmq_pkg::StoreDepthDefault - 1;
  localparam logic [sbmq_pkg::FuncW-1:0] FuncUnused = 2'd3;
  localparam int NumRows = 22;
  localparam int RandomItems = 200;
  localparam int QuietTail = 30;

  typedef struct packed {
    logic [sbmq_pkg::StatusW-1:0] status;
    logic [sbmq_pkg::ByteW-1:0]   data;
    logic                         last;
  } queue_resp_t;

  typedef struct packed {
    logic [sbmq_pkg::FuncW-1:0]   op;
    logic [sbmq_pkg::ByteW-1:0]   data;
    logic [sbmq_pkg::ReqW-1:0]    count;
    int                           reps;
    bit                           typed;
    logic [sbmq_pkg::StatusW-1:0] t_status;
    logic [sbmq_pkg::ByteW-1:0]   t_data;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [sbmq_pkg::FuncW-1:0]   func_i;
  logic [sbmq_pkg::ByteW-1:0]   data_byte_i;
  logic [sbmq_pkg::ReqW-1:0]    read_count_i;
  logic                         result_valid_o;
  logic [sbmq_pkg::StatusW-1:0] status_o;
  logic [sbmq_pkg::ByteW-1:0]   out_byte_o;
  logic                         last_o;

  logic [sbmq_pkg::ByteW-1:0] held_bytes[$];
  queue_resp_t                pending_results[$];
  queue_resp_t                oldest_resp;

  int mismatches = 0;
  int results_seen = 0;
  int data_results = 0;
  int full_rejects = 0;
  int empty_reads = 0;
  int peak_fill = 0;
  int requests_by_op[4] = '{0, 0, 0, 0};

  // extremes and special cases first, typed expectations where obvious
  stim_row_t directed_rows [NumRows] = '{
    '{sbmq_pkg::FuncRead,  8'h00, 6'd1,  1,  1'b1, sbmq_pkg::StatEmpty,    8'h00},
    '{sbmq_pkg::FuncWrite, 8'h7f, 6'd0,  1,  1'b1, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'h80, 6'd0,  1,  1'b1, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'h00, 6'd0,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'hff, 6'h3f, 1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'h80, 6'd0,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'd0,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'd1,  1,  1'b1, sbmq_pkg::StatData,     8'h80},
    '{FuncUnused,          8'hff, 6'h3f, 1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'h3f, 1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'd2,  1,  1'b1, sbmq_pkg::StatEmpty,    8'h00},
    '{sbmq_pkg::FuncWrite, 8'he0, 6'd0,  63, 1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'h01, 6'd0,  1,  1'b1, sbmq_pkg::StatFull,     8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'd5,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'h12, 6'd0,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'h3f, 1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'h55, 6'd0,  1,  1'b1, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncWrite, 8'haa, 6'd0,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncClear, 8'h00, 6'd0,  1,  1'b1, sbmq_pkg::StatCleared,  8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'h3f, 1,  1'b1, sbmq_pkg::StatEmpty,    8'h00},
    '{sbmq_pkg::FuncWrite, 8'h33, 6'd0,  1,  1'b0, sbmq_pkg::StatAccepted, 8'h00},
    '{sbmq_pkg::FuncRead,  8'h00, 6'd1,  1,  1'b1, sbmq_pkg::StatData,     8'h33}
  };

  sorted_byte_min_queue_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .read_count_i   (read_count_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void predict_queue_response(input logic [sbmq_pkg::FuncW-1:0] op,
                                                 input logic [sbmq_pkg::ByteW-1:0] data,
                                                 input logic [sbmq_pkg::ReqW-1:0] count,
                                                 output queue_resp_t resp[$]);
    int pos;
    int n;
    logic [sbmq_pkg::ByteW-1:0] b;
    resp = {};
    case (op)
      sbmq_pkg::FuncWrite: begin
        if (held_bytes.size() >= Capacity) begin
          resp.push_back('{sbmq_pkg::StatFull, 8'h00, 1'b1});
        end else begin
          pos = 0;
          while (pos < held_bytes.size() && $signed(held_bytes[pos]) <= $signed(data)) pos++;
          held_bytes.insert(pos, data);
          if (held_bytes.size() > peak_fill) peak_fill = held_bytes.size();
          resp.push_back('{sbmq_pkg::StatAccepted, 8'h00, 1'b1});
        end
      end
      sbmq_pkg::FuncRead: begin
        if (held_bytes.size() == 0) begin
          resp.push_back('{sbmq_pkg::StatEmpty, 8'h00, 1'b1});
        end else begin
          n = (int'(count) < held_bytes.size()) ? int'(count) : held_bytes.size();
          for (int i = 0; i < n; i++) begin
            b = held_bytes.pop_front();
            resp.push_back('{sbmq_pkg::StatData, b, (i == n - 1)});
          end
        end
      end
      sbmq_pkg::FuncClear: begin
        held_bytes = {};
        resp.push_back('{sbmq_pkg::StatCleared, 8'h00, 1'b1});
      end
      default: ;
    endcase
  endfunction

  // hold the request until it is taken, then queue what it should produce
  task automatic issue_request(input logic [sbmq_pkg::FuncW-1:0] op,
                               input logic [sbmq_pkg::ByteW-1:0] data,
                               input logic [sbmq_pkg::ReqW-1:0] count, input bit typed,
                               input queue_resp_t typed_resp);
    queue_resp_t resp[$];
    func_i       <= op;
    data_byte_i  <= data;
    read_count_i <= count;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_queue_response(op, data, count, resp);
    requests_by_op[op]++;
    if (typed) pending_results.push_back(typed_resp);
    else foreach (resp[k]) pending_results.push_back(resp[k]);
  endtask

  task automatic sender_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input queue_resp_t exp_resp, input bit had_exp);
    mismatches++;
    if (mismatches <= 10) begin
      if (had_exp)
        $display("mismatch at %0t: expected status %0d byte %h last %0d, got %0d %h %0d",
                 $realtime, exp_resp.status, exp_resp.data, exp_resp.last,
                 status_o, out_byte_o, last_o);
      else
        $display("unexpected result at %0t: status %0d byte %h last %0d",
                 $realtime, status_o, out_byte_o, last_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (status_o == sbmq_pkg::StatData) data_results++;
      if (status_o == sbmq_pkg::StatFull) full_rejects++;
      if (status_o == sbmq_pkg::StatEmpty) empty_reads++;
      if (pending_results.size() == 0) begin
        note_mismatch('0, 1'b0);
      end else begin
        oldest_resp = pending_results.pop_front();
        if (status_o !== oldest_resp.status || out_byte_o !== oldest_resp.data ||
            last_o !== oldest_resp.last)
          note_mismatch(oldest_resp, 1'b1);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int write_pct[4] = '{85, 50, 88, 25};
    int read_pct[4]  = '{12, 38, 10, 65};
    int clear_pct[4] = '{1, 5, 0, 5};
    int done_items;
    int phase;
    int roll;
    bit drained_once;
    logic [sbmq_pkg::FuncW-1:0] op;
    logic [sbmq_pkg::ByteW-1:0] data;
    logic [sbmq_pkg::ReqW-1:0] count;

    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = sbmq_pkg::FuncWrite;
    data_byte_i  = '0;
    read_count_i = '0;
    done_items   = 0;
    drained_once = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        issue_request(directed_rows[r].op, directed_rows[r].data + k[sbmq_pkg::ByteW-1:0],
                      directed_rows[r].count, directed_rows[r].typed,
                      '{directed_rows[r].t_status, directed_rows[r].t_data, 1'b1});
        if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 10));
      end
    end

    while (done_items < RandomItems) begin
      phase = done_items / (RandomItems / 4);
      roll = $urandom_range(0, 99);
      if (roll < write_pct[phase]) op = sbmq_pkg::FuncWrite;
      else if (roll < write_pct[phase] + read_pct[phase]) op = sbmq_pkg::FuncRead;
      else if (roll < write_pct[phase] + read_pct[phase] + clear_pct[phase])
        op = sbmq_pkg::FuncClear;
      else op = FuncUnused;

      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        case ($urandom_range(0, 3))
          0: data = 8'h00;
          1: data = 8'h7f;
          2: data = 8'h80;
          default: data = 8'hff;
        endcase
      end else if (roll < 3 && held_bytes.size() != 0) begin
        data = held_bytes[$urandom_range(0, held_bytes.size() - 1)];
      end else begin
        data = sbmq_pkg::ByteW'($urandom);
      end
      count = ($urandom_range(0, 4) == 0) ? sbmq_pkg::ReqW'($urandom_range(0, 63)) :
                                            sbmq_pkg::ReqW'($urandom_range(1, 6));

      issue_request(op, data, count, 1'b0, '0);
      if (op != FuncUnused) done_items++;

      // let the block drain completely once mid-run
      if (!drained_once && done_items >= RandomItems / 2) begin
        drained_once = 1'b1;
        start <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end else if (done_items < RandomItems - QuietTail && $urandom_range(0, 3) == 0) begin
        sender_gap($urandom_range(1, 10));
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (sbmq_pkg::StoreDepthDefault + 8) @(posedge clk_i);

    $display("requests: %0d writes, %0d reads, %0d clears, %0d unused codes",
             requests_by_op[sbmq_pkg::FuncWrite], requests_by_op[sbmq_pkg::FuncRead],
             requests_by_op[sbmq_pkg::FuncClear], requests_by_op[FuncUnused]);
    $display("results: %0d checked, %0d bytes, %0d full rejects, %0d empty reads, peak fill %0d",
             results_seen, data_results, full_rejects, empty_reads, peak_fill);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
